FILE: design/hcbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants of the chunked body decoder
// Phase codes, decoder state, result record, delimiter characters and the
// hexadecimal digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

	localparam int LENGTH_BITS = 32;
	localparam int DIGIT_BITS  = 4;

	localparam logic [DIGIT_BITS-1:0] MAX_DIGITS = DIGIT_BITS'(8);

	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	typedef enum logic [7:0] {
		PH_SIZE    = 8'b0000_0001,
		PH_EXT     = 8'b0000_0010,
		PH_SIZE_LF = 8'b0000_0100,
		PH_DATA    = 8'b0000_1000,
		PH_DATA_CR = 8'b0001_0000,
		PH_DATA_LF = 8'b0010_0000,
		PH_DONE    = 8'b0100_0000,
		PH_ERROR   = 8'b1000_0000
	} hcbd_phase_t;

	typedef struct packed {
		hcbd_phase_t             phase;
		logic [LENGTH_BITS-1:0]  bytes_left;
		logic [DIGIT_BITS-1:0]   digit_count;
	} hcbd_state_t;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       chunk_last;
		logic       body_done;
		logic       format_error;
	} hcbd_result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hcbd_hex_t;

	// Map an ASCII byte to its hex digit value; ok is low for non-digits.
	function automatic hcbd_hex_t hex_decode(input logic [7:0] c);
		hcbd_hex_t h;
		h.ok    = 1'b1;
		h.value = 4'd0;
		case (c) inside
			[8'h30:8'h39]: h.value = c[3:0];
			[8'h61:8'h66],
			[8'h41:8'h46]: h.value = c[3:0] + 4'd9;
			default:       h.ok = 1'b0;
		endcase
		return h;
	endfunction

endpackage

FILE: design/hcbd_raw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_raw_if: raw body byte channel
// Valid/ready channel carrying one byte of the chunked message body.
// ----------------------------------------------------------------------------
interface hcbd_raw_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;

	modport source (output valid, output body_byte, input ready);
	modport sink   (input valid, input body_byte, output ready);
endinterface

FILE: design/hcbd_dec_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_dec_if: decoded result channel
// Valid/ready channel carrying one decoder result per body byte.
// ----------------------------------------------------------------------------
interface hcbd_dec_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       chunk_last;
	logic       body_done;
	logic       format_error;

	modport source (
		output valid, output payload_byte, output payload_valid,
		output chunk_last, output body_done, output format_error,
		input ready
	);
	modport sink (
		input valid, input payload_byte, input payload_valid,
		input chunk_last, input body_done, input format_error,
		output ready
	);
endinterface

FILE: design/hcbd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step: per-byte phase update
// Next decoder state and the result record for one body byte.
// ----------------------------------------------------------------------------
module hcbd_step (
	input  hcbd_pkg::hcbd_state_t  cur,
	input  logic [7:0]             body_byte,
	output hcbd_pkg::hcbd_state_t  nxt,
	output hcbd_pkg::hcbd_result_t res
);

	hcbd_pkg::hcbd_hex_t hx;

	assign hx = hcbd_pkg::hex_decode(body_byte);

	always_comb begin
		nxt = cur;
		res = '0;
		unique case (cur.phase) inside
			hcbd_pkg::PH_SIZE: begin
				if (hx.ok) begin
					// Reject a ninth digit or a shift that would drop a set nibble.
					if (cur.digit_count >= hcbd_pkg::MAX_DIGITS ||
					    cur.bytes_left[hcbd_pkg::LENGTH_BITS-1 -: 4] != 4'd0) begin
						nxt.phase = hcbd_pkg::PH_ERROR;
					end else begin
						nxt.bytes_left  = {cur.bytes_left[hcbd_pkg::LENGTH_BITS-5:0], hx.value};
						nxt.digit_count = cur.digit_count + hcbd_pkg::DIGIT_BITS'(1);
					end
				end else if (cur.digit_count == '0) begin
					nxt.phase = hcbd_pkg::PH_ERROR;
				end else if (body_byte == hcbd_pkg::CH_SEMI) begin
					nxt.phase = hcbd_pkg::PH_EXT;
				end else if (body_byte == hcbd_pkg::CH_CR) begin
					nxt.phase = hcbd_pkg::PH_SIZE_LF;
				end else begin
					nxt.phase = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_EXT: begin
				if (body_byte == hcbd_pkg::CH_CR) nxt.phase = hcbd_pkg::PH_SIZE_LF;
			end
			hcbd_pkg::PH_SIZE_LF: begin
				if (body_byte != hcbd_pkg::CH_LF)  nxt.phase = hcbd_pkg::PH_ERROR;
				else if (cur.bytes_left == '0)     nxt.phase = hcbd_pkg::PH_DONE;
				else                               nxt.phase = hcbd_pkg::PH_DATA;
			end
			hcbd_pkg::PH_DATA: begin
				res.payload_byte  = body_byte;
				res.payload_valid = 1'b1;
				nxt.bytes_left    = cur.bytes_left - hcbd_pkg::LENGTH_BITS'(1);
				if (cur.bytes_left == hcbd_pkg::LENGTH_BITS'(1)) begin
					res.chunk_last = 1'b1;
					nxt.phase      = hcbd_pkg::PH_DATA_CR;
				end
			end
			hcbd_pkg::PH_DATA_CR: begin
				nxt.phase = (body_byte == hcbd_pkg::CH_CR) ? hcbd_pkg::PH_DATA_LF
				                                          : hcbd_pkg::PH_ERROR;
			end
			hcbd_pkg::PH_DATA_LF: begin
				if (body_byte == hcbd_pkg::CH_LF) begin
					nxt.phase       = hcbd_pkg::PH_SIZE;
					nxt.bytes_left  = '0;
					nxt.digit_count = '0;
				end else begin
					nxt.phase = hcbd_pkg::PH_ERROR;
				end
			end
			hcbd_pkg::PH_DONE,
			hcbd_pkg::PH_ERROR: begin
				nxt.phase = cur.phase;
			end
			default: begin
				nxt.phase = hcbd_pkg::PH_ERROR;
			end
		endcase
		res.body_done    = (nxt.phase == hcbd_pkg::PH_DONE);
		res.format_error = (nxt.phase == hcbd_pkg::PH_ERROR);
	end

endmodule

FILE: design/http_chunked_body_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer decoder
// Takes the chunked body one byte per item and returns one result per byte:
// the payload byte when it is chunk data, a last-byte flag, done and error.
// ----------------------------------------------------------------------------
// Every accepted body byte yields exactly one result item. The block sustains
// one item per clock while the result side is ready, through an input register
// and a result register, and the only loop is the update of the phase, the
// 32-bit remaining-length counter and the digit count, done in one pass of
// hcbd_step. Hex digits (either case) build the chunk size, text after ';' up
// to CR is skipped, CR LF ends the size line, then exactly size payload bytes
// are passed with chunk_last on the final one, followed by a checked CR LF.
// A zero size line raises body_done; a ninth digit, an empty size line or a
// bad delimiter raises format_error. Both flags are sticky and every later
// byte is swallowed until reset. payload_byte reads zero when payload_valid
// is low. The input stays ready while the result register can drain, so back
// pressure on the result side stalls input only when both stages are full.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder (
	input  logic              clk,
	input  logic              arst_n,
	hcbd_raw_if.sink          raw,
	hcbd_dec_if.source        decoded
);

	// Input stage.
	logic [7:0]             byte_s1;
	logic                   valid_s1;

	// Result stage.
	hcbd_pkg::hcbd_result_t res_s2;
	logic                   valid_s2;

	// Decoder state, advanced once per item leaving stage 1.
	hcbd_pkg::hcbd_state_t  state_q;
	hcbd_pkg::hcbd_state_t  state_nxt;
	hcbd_pkg::hcbd_result_t res_nxt;

	logic take_s1;
	logic adv_s1;

	// Advance stage 1 when the result register is empty or being drained.
	assign adv_s1    = valid_s1 && (!valid_s2 || decoded.ready);
	assign raw.ready = !valid_s1 || !valid_s2 || decoded.ready;
	assign take_s1   = raw.valid && raw.ready;

	hcbd_step u_step (
		.cur       (state_q),
		.body_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '{phase: hcbd_pkg::PH_SIZE, bytes_left: '0, digit_count: '0};
		end else begin
			valid_s1 <= take_s1 || (valid_s1 && !adv_s1);
			valid_s2 <= adv_s1 || (valid_s2 && !decoded.ready);
			if (adv_s1) state_q <= state_nxt;
		end
	end

	// Payload registers: load on handshake, hold otherwise.
	always_ff @(posedge clk) begin
		if (take_s1) byte_s1 <= raw.body_byte;
		if (adv_s1)  res_s2  <= res_nxt;
	end

	assign decoded.valid         = valid_s2;
	assign decoded.payload_byte  = res_s2.payload_byte;
	assign decoded.payload_valid = res_s2.payload_valid;
	assign decoded.chunk_last    = res_s2.chunk_last;
	assign decoded.body_done     = res_s2.body_done;
	assign decoded.format_error  = res_s2.format_error;

`ifndef SYNTHESIS
	// A reported error always matches the sticky error phase.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.format_error |-> state_q.phase == hcbd_pkg::PH_ERROR)
		else $error("format_error reported outside the error phase");

	// Data phase never holds an exhausted length.
	a_data_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == hcbd_pkg::PH_DATA |-> state_q.bytes_left != '0)
		else $error("data phase with zero bytes left");

	// chunk_last only marks payload.
	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.chunk_last |-> res_s2.payload_valid)
		else $error("chunk_last on a non-payload item");

	// Done and error never appear together.
	a_done_err: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> !(res_s2.body_done && res_s2.format_error))
		else $error("body_done and format_error both set");
`endif

endmodule
